// ===== rtl/mas_pkg.sv =====
// shared types and constants of the matrix add / subtract / multiply block
// no dependencies; imported by the top level, mas_ram, mas_mac and the testbench
package mas_pkg;

  localparam int WORD_W     = 32;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int OP_W       = 2;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;

  localparam logic [1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [1:0] REG_COL_COUNT = 2'd1;
  localparam logic [1:0] REG_OPERATION = 2'd2;

  localparam logic [CNT_W-1:0] ROW_COUNT_RST = 5'd16;
  localparam logic [CNT_W-1:0] COL_COUNT_RST = 5'd16;
  localparam logic [OP_W-1:0]  OPERATION_RST = OP_ADD;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SHAPE = 2'd2
  } mas_status_t;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2
  } mas_kind_t;

  typedef struct packed {
    logic                     mode;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [WORD_W-1:0] a_value;
    logic signed [WORD_W-1:0] b_value;
  } mas_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic [1:0]               status;
  } mas_out_t;

  typedef struct packed {
    logic      vld;
    logic      first;
    logic      last;
    mas_kind_t kind;
  } mas_mac_ctrl_t;

endpackage

// ===== rtl/mas_stream_if.sv =====
// valid / ready channel carrying one payload beat
// payload type comes from mas_pkg at instantiation
interface mas_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/matrix_add_sub_multiply.sv =====
// top level: register port, sequencer, A and B stores and shared unit
// depends on mas_pkg, mas_stream_if, mas_ram, mas_mac
//
// in_beat carries one item: a load writes A[r][c] and B[r][c], a fetch
// asks for element (r,c) of A+B, A-B or A*B as set by the operation
// register. out_beat returns exactly one beat per item, in order.
// Registers sit at byte addresses 0 (row_count), 4 (col_count) and
// 8 (operation); write them only while the block is idle.
// A load or an error goes to the output register without the arithmetic
// unit; add and subtract take one term, a multiply fetch sums n products
// for n columns in use, on the single multiply-accumulate unit that takes
// one product per cycle while the stores are read one address per cycle.
// in_beat.ready is high only while no item is in work, so a new item is
// taken only after the last one is done. A finished beat waits in the
// output register while the receiver stalls; the next item is accepted
// meanwhile, and its result waits inside until the register frees up.
// Reset clears the control state and sets the registers to 16, 16 and
// add; the stores are not cleared, and an element must be loaded before
// it is read.
module matrix_add_sub_multiply import mas_pkg::*; #(
  parameter int MAX_DIM = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mas_stream_if.sink            in_beat,
  mas_stream_if.source          out_beat,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN, S_HOLD} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  row_count_r;
  logic [CNT_W-1:0]  col_count_r;
  logic [OP_W-1:0]   operation_r;
  logic [CNT_W-1:0]  rows_eff;
  logic [CNT_W-1:0]  cols_eff;
  logic [IDX_W-1:0]  r_r;
  logic [IDX_W-1:0]  c_r;
  logic [CNT_W-1:0]  k_r;
  logic [CNT_W-1:0]  last_k_r;
  mas_kind_t         kind_r;
  mas_kind_t         kind_nxt;
  logic [WORD_W-1:0] res_r;
  mas_status_t       st_r;
  logic              out_vld_r;
  logic [WORD_W-1:0] out_res_r;
  mas_status_t       out_st_r;
  mas_mac_ctrl_t     issue_ctrl;
  mas_mac_ctrl_t     rd_ctrl_r;
  mas_in_t           in_item;
  logic              in_fire;
  logic              range_err;
  logic              shape_err;
  logic              ram_we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr_a;
  logic [AW-1:0]     raddr_b;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;
  logic [WORD_W-1:0] acc;
  logic              mac_done;
  logic              cfg_wr;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RST;
      col_count_r <= COL_COUNT_RST;
      operation_r <= OPERATION_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROW_COUNT: row_count_r <= pwdata[CNT_W-1:0];
        REG_COL_COUNT: col_count_r <= pwdata[CNT_W-1:0];
        REG_OPERATION: operation_r <= pwdata[OP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROW_COUNT: prdata = CFG_DATA_W'(row_count_r);
      REG_COL_COUNT: prdata = CFG_DATA_W'(col_count_r);
      REG_OPERATION: prdata = CFG_DATA_W'(operation_r);
      default:       prdata = '0;
    endcase
  end

  // counts in use: zero acts as one, above the store size is clamped
  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = CNT_W'(1);
    end else if (7'(row_count_r) > 7'(MAX_DIM)) begin
      rows_eff = CNT_W'(MAX_DIM);
    end else begin
      rows_eff = row_count_r;
    end
    if (col_count_r == '0) begin
      cols_eff = CNT_W'(1);
    end else if (7'(col_count_r) > 7'(MAX_DIM)) begin
      cols_eff = CNT_W'(MAX_DIM);
    end else begin
      cols_eff = col_count_r;
    end
  end

  always_comb begin
    case (operation_r)
      OP_SUB:  kind_nxt = KIND_SUB;
      OP_MUL:  kind_nxt = KIND_MUL;
      default: kind_nxt = KIND_ADD;
    endcase
  end

  // input beat checks
  assign in_item   = in_beat.payload;
  assign in_beat.ready = (state_r == S_IDLE);
  assign in_fire   = in_beat.valid && in_beat.ready;
  assign range_err = (CNT_W'(in_item.row_index) >= rows_eff) ||
                     (CNT_W'(in_item.col_index) >= cols_eff);
  assign shape_err = (kind_nxt == KIND_MUL) && (rows_eff != cols_eff);

  // store addressing
  assign ram_we  = in_fire && !range_err && (in_item.mode == MODE_LOAD);
  assign waddr   = AW'(in_item.row_index) * AW'(MAX_DIM) + AW'(in_item.col_index);
  assign raddr_a = (kind_r == KIND_MUL) ? AW'(r_r) * AW'(MAX_DIM) + AW'(k_r)
                                        : AW'(r_r) * AW'(MAX_DIM) + AW'(c_r);
  assign raddr_b = (kind_r == KIND_MUL) ? AW'(k_r) * AW'(MAX_DIM) + AW'(c_r)
                                        : AW'(r_r) * AW'(MAX_DIM) + AW'(c_r);

  assign issue_ctrl = '{vld:   (state_r == S_ISSUE),
                        first: (k_r == '0),
                        last:  (k_r == last_k_r),
                        kind:  kind_r};

  mas_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_a (
    .clk     (clk),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (in_item.a_value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mas_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_b (
    .clk     (clk),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (in_item.b_value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  mas_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (rd_ctrl_r),
    .a_i    (rdata_a),
    .b_i    (rdata_b),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_vld_r     <= 1'b0;
      rd_ctrl_r.vld <= 1'b0;
    end else begin
      rd_ctrl_r.vld <= issue_ctrl.vld;
      if (state_r == S_HOLD && (!out_vld_r || out_beat.ready)) begin
        out_vld_r <= 1'b1;
      end else if (out_beat.valid && out_beat.ready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (range_err) begin
              state_r <= S_HOLD;
            end else if (in_item.mode == MODE_LOAD || shape_err) begin
              state_r <= S_HOLD;
            end else begin
              state_r <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (k_r == last_k_r) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (mac_done) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_vld_r || out_beat.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end

    rd_ctrl_r.first <= issue_ctrl.first;
    rd_ctrl_r.last  <= issue_ctrl.last;
    rd_ctrl_r.kind  <= issue_ctrl.kind;

    case (state_r)
      S_IDLE: begin
        r_r      <= in_item.row_index;
        c_r      <= in_item.col_index;
        k_r      <= '0;
        kind_r   <= kind_nxt;
        last_k_r <= (kind_nxt == KIND_MUL) ? cols_eff - CNT_W'(1) : '0;
        res_r    <= '0;
        if (range_err) begin
          st_r <= ST_RANGE;
        end else if (in_item.mode == MODE_FETCH && shape_err) begin
          st_r <= ST_SHAPE;
        end else begin
          st_r <= ST_OK;
        end
      end
      S_ISSUE: begin
        k_r <= k_r + CNT_W'(1);
      end
      S_DRAIN: begin
        if (mac_done) begin
          res_r <= acc;
        end
      end
      S_HOLD: begin
        if (!out_vld_r || out_beat.ready) begin
          out_res_r <= res_r;
          out_st_r  <= st_r;
        end
      end
      default: ;
    endcase
  end

  assign out_beat.valid   = out_vld_r;
  assign out_beat.payload = {out_res_r, out_st_r};

endmodule

// ===== rtl/mas_ram.sv =====
// single write, single read port memory with registered read data
// uses mas_pkg for the word width
module mas_ram import mas_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
    rdata_r <= mem_r[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

// ===== rtl/mas_mac.sv =====
// shared arithmetic unit: one add, subtract or product term per cycle,
// registered, then accumulated; uses mas_pkg control struct
module mas_mac import mas_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mas_mac_ctrl_t     ctrl_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  output logic [WORD_W-1:0] acc_o,
  output logic              done_o
);

  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] term;
  logic [WORD_W-1:0] term_r;
  logic              term_vld_r;
  logic              term_first_r;
  logic              term_last_r;
  logic [WORD_W-1:0] acc_r;
  logic              done_r;

  // low half of the product is all that survives the 32 bit wrap
  assign prod = a_i * b_i;

  always_comb begin
    case (ctrl_i.kind)
      KIND_SUB: term = a_i - b_i;
      KIND_MUL: term = prod;
      default:  term = a_i + b_i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_vld_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      term_vld_r <= ctrl_i.vld;
      done_r     <= term_vld_r && term_last_r;
    end
    term_r       <= term;
    term_first_r <= ctrl_i.first;
    term_last_r  <= ctrl_i.last;
    if (term_vld_r) begin
      acc_r <= term_first_r ? term_r : acc_r + term_r;
    end
  end

  assign acc_o  = acc_r;
  assign done_o = done_r;

endmodule

// ===== verif/tb_matrix_add_sub_multiply.sv =====
// self-checking testbench for matrix_add_sub_multiply: element loads and fetches
// checked against an in-bench model of the add / subtract / multiply engine
// depends on mas_pkg, mas_stream_if and the block's rtl
`timescale 1ns / 1ps

module tb_matrix_add_sub_multiply;
  import mas_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int DIM = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mas_stream_if #(.payload_t(mas_in_t))  in_ch ();
  mas_stream_if #(.payload_t(mas_out_t)) out_ch ();

  matrix_add_sub_multiply #(.MAX_DIM(DIM)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_ch),
    .out_beat(out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model copy of the registers and element stores
  logic [CNT_W-1:0]  rows_shadow;
  logic [CNT_W-1:0]  cols_shadow;
  logic [OP_W-1:0]   op_shadow;
  logic [WORD_W-1:0] a_elems [DIM*DIM];
  logic [WORD_W-1:0] b_elems [DIM*DIM];

  mas_in_t  item_q[$];
  mas_out_t elem_expect_q[$];
  int       issued_count = 0;
  int       done_count = 0;
  int       error_count = 0;
  int       src_idle_pct = 19;
  int       snk_idle_pct = 83;

  function automatic int eff_dim(logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  function automatic mas_out_t predict_element(mas_in_t it);
    mas_out_t    res;
    int          rows;
    int          cols;
    logic [31:0] acc;
    logic [3:0]  k4;
    rows = eff_dim(rows_shadow);
    cols = eff_dim(cols_shadow);
    res.result_value = '0;
    res.status = ST_OK;
    if (it.row_index >= rows || it.col_index >= cols) begin
      res.status = ST_RANGE;
    end else if (it.mode == MODE_LOAD) begin
      a_elems[{it.row_index, it.col_index}] = it.a_value;
      b_elems[{it.row_index, it.col_index}] = it.b_value;
    end else begin
      case (op_shadow)
        OP_SUB: begin
          res.result_value = a_elems[{it.row_index, it.col_index}] -
                             b_elems[{it.row_index, it.col_index}];
        end
        OP_MUL: begin
          if (rows != cols) begin
            res.status = ST_SHAPE;
          end else begin
            acc = '0;
            for (int k = 0; k < cols; k++) begin
              k4 = 4'(k);
              acc = acc + a_elems[{it.row_index, k4}] * b_elems[{k4, it.col_index}];
            end
            res.result_value = acc;
          end
        end
        default: begin
          res.result_value = a_elems[{it.row_index, it.col_index}] +
                             b_elems[{it.row_index, it.col_index}];
        end
      endcase
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 50) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // input driver: holds a beat until taken, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) elem_expect_q.push_back(predict_element(in_ch.payload));
      if (!in_ch.valid || in_ch.ready) begin
        if (item_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.payload <= item_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_mon
    mas_out_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        done_count++;
        if (elem_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat value=%0d status=%0d",
                                    out_ch.payload.result_value, out_ch.payload.status));
        end else begin
          want = elem_expect_q.pop_front();
          if (out_ch.payload.result_value !== want.result_value)
            report_mismatch($sformatf("result_value got %0d want %0d",
                                      out_ch.payload.result_value, want.result_value));
          if (out_ch.payload.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_ch.payload.status, want.status));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ROW_COUNT: rows_shadow = val[CNT_W-1:0];
      REG_COL_COUNT: cols_shadow = val[CNT_W-1:0];
      REG_OPERATION: op_shadow = val[OP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols,
                              input logic [OP_W-1:0] op);
    write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
    write_reg(REG_COL_COUNT, CFG_DATA_W'(cols));
    write_reg(REG_OPERATION, CFG_DATA_W'(op));
  endtask

  task automatic wait_drain();
    while (done_count < issued_count) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_item(input logic mode, input int r, input int c,
                            input logic [31:0] a, input logic [31:0] b);
    mas_in_t it;
    it.mode = mode;
    it.row_index = 4'(r);
    it.col_index = 4'(c);
    it.a_value = a;
    it.b_value = b;
    item_q.push_back(it);
    issued_count++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(9))
      7, 8: return $urandom_range(8, 5);
      9: return $urandom_range(15, 9);
      default: return $urandom_range(4, 1);
    endcase
  endfunction

  // raw register value for a dimension, with out-of-range codes that clamp
  function automatic logic [CNT_W-1:0] encode_dim(input int n);
    if (n == 1 && $urandom_range(2) == 0) return '0;
    if (n == DIM && $urandom_range(1) == 0) return CNT_W'($urandom_range(31, DIM + 1));
    return CNT_W'(n);
  endfunction

  task automatic run_random_phase(input int phase_no, inout int item_total);
    int               n_r;
    int               n_c;
    int               fetches;
    int               pick;
    int               r;
    int               c;
    logic [OP_W-1:0]  op;
    op = OP_W'($urandom_range(3));
    n_r = (phase_no % 10 == 4) ? DIM : pick_dim();
    if (op == OP_MUL && $urandom_range(3) != 0) n_c = n_r;
    else n_c = (phase_no % 10 == 4 && $urandom_range(1) == 0) ? DIM : pick_dim();
    apply_config(encode_dim(n_r), encode_dim(n_c), op);

    // well-formed: fill the whole active region before any fetch
    for (int i = 0; i < n_r; i++)
      for (int j = 0; j < n_c; j++)
        queue_item(MODE_LOAD, i, j, pick_word(), pick_word());
    if (phase_no % 7 == 3) wait_drain();

    fetches = $urandom_range(40, 20);
    for (int n = 0; n < fetches; n++) begin
      pick = $urandom_range(99);
      if (pick >= 85 && !(n_r == DIM && n_c == DIM)) begin
        if (n_r < DIM && (n_c == DIM || $urandom_range(1) == 0)) begin
          r = $urandom_range(15, n_r);
          c = $urandom_range(15);
        end else begin
          r = $urandom_range(15);
          c = $urandom_range(15, n_c);
        end
        queue_item(1'($urandom_range(1)), r, c, pick_word(), pick_word());
      end else if (pick >= 70) begin
        queue_item(MODE_LOAD, $urandom_range(n_r - 1), $urandom_range(n_c - 1),
                   pick_word(), pick_word());
      end else begin
        queue_item(MODE_FETCH, $urandom_range(n_r - 1), $urandom_range(n_c - 1),
                   $urandom(), $urandom());
      end
    end
    item_total += n_r * n_c + fetches;
    wait_drain();
  endtask

  initial begin : stimulus
    int item_total;
    int phase_no;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rows_shadow = ROW_COUNT_RST;
    cols_shadow = COL_COUNT_RST;
    op_shadow = OPERATION_RST;
    for (int i = 0; i < DIM*DIM; i++) begin
      a_elems[i] = '0;
      b_elems[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: 16 by 16, add; corners and word extremes
    queue_item(MODE_LOAD, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_item(MODE_LOAD, 15, 15, 32'h8000_0000, 32'h8000_0000);
    queue_item(MODE_LOAD, 0, 15, 32'hffff_ffff, 32'h0000_0001);
    queue_item(MODE_LOAD, 15, 0, 32'h5555_5555, 32'haaaa_aaaa);
    queue_item(MODE_FETCH, 0, 0, $urandom(), $urandom());
    queue_item(MODE_FETCH, 15, 15, $urandom(), $urandom());
    queue_item(MODE_FETCH, 0, 15, 32'hffff_ffff, 32'hffff_ffff);
    queue_item(MODE_FETCH, 15, 0, $urandom(), $urandom());
    wait_drain();

    apply_config(5'd16, 5'd16, OP_SUB);
    queue_item(MODE_FETCH, 0, 0, $urandom(), $urandom());
    queue_item(MODE_FETCH, 15, 15, $urandom(), $urandom());
    queue_item(MODE_FETCH, 0, 15, $urandom(), $urandom());
    queue_item(MODE_FETCH, 15, 0, $urandom(), $urandom());
    wait_drain();

    // non-square multiply and range errors
    apply_config(5'd2, 5'd3, OP_MUL);
    queue_item(MODE_FETCH, 0, 0, $urandom(), $urandom());
    queue_item(MODE_LOAD, 2, 0, $urandom(), $urandom());
    queue_item(MODE_LOAD, 0, 3, $urandom(), $urandom());
    queue_item(MODE_FETCH, 15, 15, $urandom(), $urandom());
    queue_item(MODE_LOAD, 1, 2, $urandom(), $urandom());
    wait_drain();

    apply_config(5'd1, 5'd1, OP_MUL);
    queue_item(MODE_FETCH, 0, 0, $urandom(), $urandom());
    queue_item(MODE_FETCH, 1, 0, $urandom(), $urandom());
    wait_drain();

    // zero and oversize counts clamp, spare operation code acts as add
    apply_config(5'd0, 5'd31, OP_SPARE);
    queue_item(MODE_FETCH, 0, 15, $urandom(), $urandom());
    queue_item(MODE_FETCH, 1, 0, $urandom(), $urandom());
    wait_drain();

    apply_config(5'd31, 5'd0, OP_SUB);
    queue_item(MODE_FETCH, 15, 0, $urandom(), $urandom());
    queue_item(MODE_LOAD, 3, 1, $urandom(), $urandom());
    wait_drain();

    item_total = 0;
    phase_no = 0;
    while (item_total < 1600) begin
      if (item_total < 533) begin
        src_idle_pct = 19;
        snk_idle_pct = 83;
      end else if (item_total < 1066) begin
        src_idle_pct = 83;
        snk_idle_pct = 19;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      run_random_phase(phase_no, item_total);
      phase_no++;
    end

    wait_drain();
    repeat (40) @(posedge clk);
    if (elem_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", elem_expect_q.size()));
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mas_pkg.sv
rtl/mas_stream_if.sv
rtl/mas_ram.sv
rtl/mas_mac.sv
rtl/matrix_add_sub_multiply.sv
verif/tb_matrix_add_sub_multiply.sv
